[design/rgb2hsv_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rgb2hsv_pkg: shared types and constants for the RGB to HSV converter
// Holds the hue sector encoding, the control word that follows a pixel down
// the divider, and the fixed hue scale in sixteenths of a degree.
// ----------------------------------------------------------------------------
package rgb2hsv_pkg;

    localparam int HUE_W        = 13;
    localparam int HUE_QUO_BITS = 10;

    localparam logic [HUE_W-1:0] HUE_SECTOR     = 13'd960;
    localparam logic [HUE_W-1:0] HUE_GREEN_BASE = 13'd1920;
    localparam logic [HUE_W-1:0] HUE_BLUE_BASE  = 13'd3840;
    localparam logic [HUE_W-1:0] HUE_TURN       = 13'd5760;

    typedef enum logic [1:0] {
        SEC_RED   = 2'd0,
        SEC_GREEN = 2'd1,
        SEC_BLUE  = 2'd2
    } t_sector;

    typedef struct packed {
        t_sector sector;
        logic    neg;
        logic    undef;
    } t_hue_ctl;

endpackage
`default_nettype wire

[design/rgb_to_hsv_convert.sv]
`timescale 1ns / 1ps
`default_nettype none
// o_strobe rises after the front stages, the divider stages and the output register;
// the restoring dividers take one quotient bit per stage.
// Throughput: one pixel per clock; busy is always low and the receiver cannot stall.
// Reset: synchronous, active low, clears the valid bits of every stage; data is not reset.
// ----------------------------------------------------------------------------
// rgb_to_hsv_convert: pipelined RGB to HSV pixel converter
// Value is the largest component, saturation is delta*FULL/max and hue is
// given in sixteenths of a degree, zero and flagged when it has no meaning.
// ----------------------------------------------------------------------------
module rgb_to_hsv_convert #(
    parameter int COLOR_BITS = 8
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic [COLOR_BITS-1:0]         i_red_in,
    input  wire logic [COLOR_BITS-1:0]         i_green_in,
    input  wire logic [COLOR_BITS-1:0]         i_blue_in,
    output logic                               o_strobe,
    output logic [rgb2hsv_pkg::HUE_W-1:0]      o_hue_out,
    output logic [COLOR_BITS-1:0]              o_sat_out,
    output logic [COLOR_BITS-1:0]              o_val_out,
    output logic                               o_hue_undefined
);

    localparam int QW  = (COLOR_BITS > rgb2hsv_pkg::HUE_QUO_BITS) ?
                         COLOR_BITS : rgb2hsv_pkg::HUE_QUO_BITS;
    localparam int CW  = $bits(rgb2hsv_pkg::t_hue_ctl);
    localparam int LAT = QW + 3;

    logic                      f_valid;
    logic [2*COLOR_BITS-1:0]   f_sat_num;
    logic [COLOR_BITS-1:0]     f_sat_den;
    logic [COLOR_BITS+9:0]     f_hue_num;
    logic [COLOR_BITS-1:0]     f_hue_den;
    rgb2hsv_pkg::t_hue_ctl     f_ctl;

    logic [QW-1:0]             s_quo;
    logic [COLOR_BITS-1:0]     s_val;
    logic                      h_valid;
    logic [QW-1:0]             h_quo;
    logic                      h_rem_nz;
    logic [CW-1:0]             h_side;

    assign busy = 1'b0;

    rgb2hsv_front #(
        .COLOR_BITS (COLOR_BITS)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (start),
        .i_red     (i_red_in),
        .i_green   (i_green_in),
        .i_blue    (i_blue_in),
        .o_valid   (f_valid),
        .o_sat_num (f_sat_num),
        .o_sat_den (f_sat_den),
        .o_hue_num (f_hue_num),
        .o_hue_den (f_hue_den),
        .o_ctl     (f_ctl)
    );

    rgb2hsv_div #(
        .NW (2 * COLOR_BITS),
        .DW (COLOR_BITS),
        .QW (QW),
        .SW (COLOR_BITS)
    ) u_sat_div (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (f_valid),
        .i_num    (f_sat_num),
        .i_den    (f_sat_den),
        .i_side   (f_sat_den),
        .o_valid  (),
        .o_quo    (s_quo),
        .o_rem_nz (),
        .o_side   (s_val)
    );

    rgb2hsv_div #(
        .NW (COLOR_BITS + 10),
        .DW (COLOR_BITS),
        .QW (QW),
        .SW (CW)
    ) u_hue_div (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (f_valid),
        .i_num    (f_hue_num),
        .i_den    (f_hue_den),
        .i_side   (f_ctl),
        .o_valid  (h_valid),
        .o_quo    (h_quo),
        .o_rem_nz (h_rem_nz),
        .o_side   (h_side)
    );

    rgb2hsv_back #(
        .COLOR_BITS (COLOR_BITS),
        .QW         (QW)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (h_valid),
        .i_hue_quo    (h_quo),
        .i_hue_rem_nz (h_rem_nz),
        .i_ctl        (rgb2hsv_pkg::t_hue_ctl'(h_side)),
        .i_sat_quo    (s_quo),
        .i_val        (s_val),
        .o_strobe     (o_strobe),
        .o_hue        (o_hue_out),
        .o_sat        (o_sat_out),
        .o_val        (o_val_out),
        .o_undef      (o_hue_undefined)
    );

`ifndef SYNTHESIS
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start |-> ##LAT o_strobe)
        else $error("pixel word did not arrive at the fixed latency");

    a_hue_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> (o_hue_out < rgb2hsv_pkg::HUE_TURN))
        else $error("hue word outside one turn");

    a_undef_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_hue_undefined) |-> (o_hue_out == '0 && o_sat_out == '0))
        else $error("undefined hue word carries nonzero hue or saturation");

    a_defined_val: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_hue_undefined) |-> (o_val_out != '0 && o_sat_out != '0))
        else $error("defined hue word with zero value or saturation");
`endif

endmodule
`default_nettype wire

[design/rgb2hsv_front.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rgb2hsv_front: extremes, sector and divider operands
// The first stage finds the largest and smallest components and the sector.
// The second stage forms delta, the signed hue difference and both dividends.
// ----------------------------------------------------------------------------
module rgb2hsv_front #(
    parameter int COLOR_BITS = 8
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_valid,
    input  wire logic [COLOR_BITS-1:0]     i_red,
    input  wire logic [COLOR_BITS-1:0]     i_green,
    input  wire logic [COLOR_BITS-1:0]     i_blue,
    output logic                           o_valid,
    output logic [2*COLOR_BITS-1:0]        o_sat_num,
    output logic [COLOR_BITS-1:0]          o_sat_den,
    output logic [COLOR_BITS+9:0]          o_hue_num,
    output logic [COLOR_BITS-1:0]          o_hue_den,
    output rgb2hsv_pkg::t_hue_ctl          o_ctl
);

    localparam int SNW = 2 * COLOR_BITS;
    localparam int HNW = COLOR_BITS + 10;

    logic                      r_a_valid;
    logic [COLOR_BITS-1:0]     r_mx;
    logic [COLOR_BITS-1:0]     r_mn;
    logic [COLOR_BITS-1:0]     r_p;
    logic [COLOR_BITS-1:0]     r_q;
    rgb2hsv_pkg::t_sector      r_sec;

    rgb2hsv_pkg::t_sector      n_sec;
    logic [COLOR_BITS-1:0]     n_mx;
    logic [COLOR_BITS-1:0]     n_mn;
    logic [COLOR_BITS-1:0]     n_p;
    logic [COLOR_BITS-1:0]     n_q;

    logic                      r_valid;
    logic [SNW-1:0]            r_sat_num;
    logic [COLOR_BITS-1:0]     r_sat_den;
    logic [HNW-1:0]            r_hue_num;
    logic [COLOR_BITS-1:0]     r_hue_den;
    rgb2hsv_pkg::t_hue_ctl     r_ctl;

    logic [COLOR_BITS-1:0]     delta;
    logic                      neg;
    logic [COLOR_BITS-1:0]     mag;

    always_comb begin
        if (i_red >= i_green && i_red >= i_blue) begin
            n_sec = rgb2hsv_pkg::SEC_RED;
            n_mx  = i_red;
            n_p   = i_green;
            n_q   = i_blue;
        end else if (i_green >= i_blue) begin
            n_sec = rgb2hsv_pkg::SEC_GREEN;
            n_mx  = i_green;
            n_p   = i_blue;
            n_q   = i_red;
        end else begin
            n_sec = rgb2hsv_pkg::SEC_BLUE;
            n_mx  = i_blue;
            n_p   = i_red;
            n_q   = i_green;
        end
        n_mn = i_red;
        if (i_green < n_mn) begin
            n_mn = i_green;
        end
        if (i_blue < n_mn) begin
            n_mn = i_blue;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else begin
            r_a_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mx  <= n_mx;
        r_mn  <= n_mn;
        r_p   <= n_p;
        r_q   <= n_q;
        r_sec <= n_sec;
    end

    assign delta = r_mx - r_mn;
    assign neg   = (r_p < r_q);
    assign mag   = neg ? (r_q - r_p) : (r_p - r_q);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= r_a_valid;
        end
    end

    // The hue sector span of 960 is formed as 1024 minus 64.
    always_ff @(posedge i_clk) begin
        r_sat_num    <= (SNW'(delta) << COLOR_BITS) - SNW'(delta);
        r_sat_den    <= r_mx;
        r_hue_num    <= (HNW'(mag) << 10) - (HNW'(mag) << 6);
        r_hue_den    <= delta;
        r_ctl.sector <= r_sec;
        r_ctl.neg    <= neg;
        r_ctl.undef  <= (delta == '0);
    end

    assign o_valid   = r_valid;
    assign o_sat_num = r_sat_num;
    assign o_sat_den = r_sat_den;
    assign o_hue_num = r_hue_num;
    assign o_hue_den = r_hue_den;
    assign o_ctl     = r_ctl;

endmodule
`default_nettype wire

[design/rgb2hsv_div.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rgb2hsv_div: pipelined restoring divider
// Produces one quotient bit per stage, most significant first, with the
// divisor and a sideband word carried alongside. The dividend must be
// smaller than the divisor shifted up by the quotient width.
// ----------------------------------------------------------------------------
module rgb2hsv_div #(
    parameter int NW = 16,
    parameter int DW = 8,
    parameter int QW = 10,
    parameter int SW = 8
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    input  wire logic [NW-1:0] i_num,
    input  wire logic [DW-1:0] i_den,
    input  wire logic [SW-1:0] i_side,
    output logic               o_valid,
    output logic [QW-1:0]      o_quo,
    output logic               o_rem_nz,
    output logic [SW-1:0]      o_side
);

    localparam int RW = DW + QW;

    logic [QW-1:0] r_valid;
    logic [RW-1:0] r_rem  [QW];
    logic [QW-1:0] r_quo  [QW];
    logic [SW-1:0] r_side [QW];
    logic [DW-1:0] r_den  [QW-1];

    for (genvar k = 0; k < QW; k++) begin : g_stage
        localparam int BIT = QW - 1 - k;

        logic          src_valid;
        logic [RW-1:0] src_rem;
        logic [QW-1:0] src_quo;
        logic [DW-1:0] src_den;
        logic [SW-1:0] src_side;
        logic [RW-1:0] shifted;
        logic [RW-1:0] n_rem;
        logic [QW-1:0] n_quo;

        if (k == 0) begin : g_first
            assign src_valid = i_valid;
            assign src_rem   = RW'(i_num);
            assign src_quo   = '0;
            assign src_den   = i_den;
            assign src_side  = i_side;
        end else begin : g_next
            assign src_valid = r_valid[k-1];
            assign src_rem   = r_rem[k-1];
            assign src_quo   = r_quo[k-1];
            assign src_den   = r_den[k-1];
            assign src_side  = r_side[k-1];
        end

        assign shifted = RW'(src_den) << BIT;

        always_comb begin
            n_rem = src_rem;
            n_quo = src_quo;
            if (src_rem >= shifted) begin
                n_rem      = src_rem - shifted;
                n_quo[BIT] = 1'b1;
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[k] <= 1'b0;
            end else begin
                r_valid[k] <= src_valid;
            end
        end

        always_ff @(posedge i_clk) begin
            r_rem[k]  <= n_rem;
            r_quo[k]  <= n_quo;
            r_side[k] <= src_side;
        end

        if (k < QW - 1) begin : g_den
            always_ff @(posedge i_clk) begin
                r_den[k] <= src_den;
            end
        end
    end

    assign o_valid  = r_valid[QW-1];
    assign o_quo    = r_quo[QW-1];
    assign o_rem_nz = |r_rem[QW-1];
    assign o_side   = r_side[QW-1];

endmodule
`default_nettype wire

[design/rgb2hsv_back.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rgb2hsv_back: hue assembly and output register
// Adds the sector base to the hue quotient, floors negative differences, wraps
// the red sector into one turn and zeroes hue and saturation when undefined.
// ----------------------------------------------------------------------------
module rgb2hsv_back #(
    parameter int COLOR_BITS = 8,
    parameter int QW         = 10
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_valid,
    input  wire logic [QW-1:0]          i_hue_quo,
    input  wire logic                   i_hue_rem_nz,
    input  wire rgb2hsv_pkg::t_hue_ctl  i_ctl,
    input  wire logic [QW-1:0]          i_sat_quo,
    input  wire logic [COLOR_BITS-1:0]  i_val,
    output logic                        o_strobe,
    output logic [rgb2hsv_pkg::HUE_W-1:0] o_hue,
    output logic [COLOR_BITS-1:0]       o_sat,
    output logic [COLOR_BITS-1:0]       o_val,
    output logic                        o_undef
);

    localparam int HW = rgb2hsv_pkg::HUE_W;

    logic                  r_strobe;
    logic [HW-1:0]         r_hue;
    logic [COLOR_BITS-1:0] r_sat;
    logic [COLOR_BITS-1:0] r_val;
    logic                  r_undef;

    logic [HW-1:0] quo;
    logic [HW-1:0] base;
    logic [HW-1:0] n_hue;

    assign quo = HW'(i_hue_quo);

    always_comb begin
        case (i_ctl.sector)
            rgb2hsv_pkg::SEC_RED: begin
                base = i_ctl.neg ? rgb2hsv_pkg::HUE_TURN : '0;
            end
            rgb2hsv_pkg::SEC_GREEN: begin
                base = rgb2hsv_pkg::HUE_GREEN_BASE;
            end
            rgb2hsv_pkg::SEC_BLUE: begin
                base = rgb2hsv_pkg::HUE_BLUE_BASE;
            end
            default: begin
                base = '0;
            end
        endcase
        if (i_ctl.undef) begin
            n_hue = '0;
        end else if (i_ctl.neg) begin
            n_hue = base - quo - HW'(i_hue_rem_nz);
        end else begin
            n_hue = base + quo;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_hue   <= n_hue;
        r_sat   <= i_ctl.undef ? '0 : COLOR_BITS'(i_sat_quo);
        r_val   <= i_val;
        r_undef <= i_ctl.undef;
    end

    assign o_strobe = r_strobe;
    assign o_hue    = r_hue;
    assign o_sat    = r_sat;
    assign o_val    = r_val;
    assign o_undef  = r_undef;

endmodule
`default_nettype wire

[dv/rgb_to_hsv_convert_chk.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgb_to_hsv_convert_chk: result checker for the RGB to HSV converter
// Watches the pixel and result channels and computes hue, saturation and value
// for every accepted pixel. It compares each result word in order and reports
// each mismatch by field.
// ----------------------------------------------------------------------------
module rgb_to_hsv_convert_chk #(
    parameter int COLOR_BITS = 8
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic                          i_busy,
    input  logic [COLOR_BITS-1:0]         i_red,
    input  logic [COLOR_BITS-1:0]         i_green,
    input  logic [COLOR_BITS-1:0]         i_blue,
    input  logic                          i_strobe,
    input  logic [rgb2hsv_pkg::HUE_W-1:0] i_hue,
    input  logic [COLOR_BITS-1:0]         i_sat,
    input  logic [COLOR_BITS-1:0]         i_val,
    input  logic                          i_hue_undefined,
    output int                            o_fail_count,
    output int                            o_pending,
    output int                            o_checked,
    output int                            o_undef_seen
);

    typedef struct packed {
        logic [rgb2hsv_pkg::HUE_W-1:0] hue;
        logic [COLOR_BITS-1:0]         sat;
        logic [COLOR_BITS-1:0]         val;
        logic                          undef;
    } t_hsv;

    t_hsv hsv_expected_q[$];

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        o_checked    = 0;
        o_undef_seen = 0;
    end

    function automatic t_hsv hsv_of_pixel(input logic [COLOR_BITS-1:0] r,
                                          input logic [COLOR_BITS-1:0] g,
                                          input logic [COLOR_BITS-1:0] b);
        t_hsv                 res;
        rgb2hsv_pkg::t_sector sector;
        int      red;
        int      grn;
        int      blu;
        int      top;
        int      bot;
        int      delta;
        int      num;
        int      base;
        int      quot;
        int      hue;
        longint  full;
        longint  sat_wide;
        red   = int'(r);
        grn   = int'(g);
        blu   = int'(b);
        top   = red;
        bot   = red;
        if (grn > top) top = grn;
        if (blu > top) top = blu;
        if (grn < bot) bot = grn;
        if (blu < bot) bot = blu;
        delta = top - bot;
        res   = '0;
        res.val = top[COLOR_BITS-1:0];
        if (top == 0 || delta == 0) begin
            res.undef = 1'b1;
        end else begin
            full     = (longint'(1) << COLOR_BITS) - 1;
            sat_wide = (longint'(delta) * full) / longint'(top);
            res.sat  = sat_wide[COLOR_BITS-1:0];
            if (red == top) begin
                sector = rgb2hsv_pkg::SEC_RED;
            end else if (grn == top) begin
                sector = rgb2hsv_pkg::SEC_GREEN;
            end else begin
                sector = rgb2hsv_pkg::SEC_BLUE;
            end
            case (sector)
                rgb2hsv_pkg::SEC_RED: begin
                    base = 0;
                    num  = int'(rgb2hsv_pkg::HUE_SECTOR) * (grn - blu);
                end
                rgb2hsv_pkg::SEC_GREEN: begin
                    base = int'(rgb2hsv_pkg::HUE_GREEN_BASE);
                    num  = int'(rgb2hsv_pkg::HUE_SECTOR) * (blu - red);
                end
                default: begin
                    base = int'(rgb2hsv_pkg::HUE_BLUE_BASE);
                    num  = int'(rgb2hsv_pkg::HUE_SECTOR) * (red - grn);
                end
            endcase
            // Division rounds toward minus infinity, not toward zero.
            quot = (num >= 0) ? num / delta : -((-num + delta - 1) / delta);
            hue  = base + quot;
            if (hue < 0) hue += int'(rgb2hsv_pkg::HUE_TURN);
            res.hue = hue[rgb2hsv_pkg::HUE_W-1:0];
        end
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_hsv want;
        if (i_rst_n) begin
            if (i_strobe) begin
                if (hsv_expected_q.size() == 0) begin
                    $error("result word with no pixel outstanding: hue %0d sat %0d val %0d",
                           i_hue, i_sat, i_val);
                    o_fail_count++;
                end else begin
                    want = hsv_expected_q.pop_front();
                    if (i_hue !== want.hue) begin
                        $error("hue_out: expected %0d, actual %0d", want.hue, i_hue);
                        o_fail_count++;
                    end
                    if (i_sat !== want.sat) begin
                        $error("sat_out: expected %0d, actual %0d", want.sat, i_sat);
                        o_fail_count++;
                    end
                    if (i_val !== want.val) begin
                        $error("val_out: expected %0d, actual %0d", want.val, i_val);
                        o_fail_count++;
                    end
                    if (i_hue_undefined !== want.undef) begin
                        $error("hue_undefined: expected %0d, actual %0d",
                               want.undef, i_hue_undefined);
                        o_fail_count++;
                    end
                    o_checked++;
                    if (want.undef) o_undef_seen++;
                end
            end
            if (i_start && !i_busy) begin
                hsv_expected_q.push_back(hsv_of_pixel(i_red, i_green, i_blue));
            end
            o_pending = hsv_expected_q.size();
        end
    end

endmodule

[dv/rgb_to_hsv_convert_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgb_to_hsv_convert_tb: testbench top for the RGB to HSV converter
// Sends a directed set of edge pixels, then random pixels biased toward
// greys, ties and dark values, with random gaps between words. A checker
// beside the block predicts and compares every result word.
// ----------------------------------------------------------------------------
module rgb_to_hsv_convert_tb;

    localparam int COLOR_BITS    = 8;
    localparam int CHANNEL_MAX   = (1 << COLOR_BITS) - 1;
    localparam int RANDOM_PIXELS = 1300;
    localparam int DRAIN_CYCLES  = 40;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int EDGE_COUNT    = 24;

    // Red, green and blue packed from high byte to low byte.
    localparam logic [23:0] EDGE_PIXELS [EDGE_COUNT] = '{
        24'h000000, 24'hFFFFFF, 24'h808080, 24'h010101,
        24'hFF0000, 24'h00FF00, 24'h0000FF, 24'hFFFF00,
        24'h00FFFF, 24'hFF00FF, 24'hFF0001, 24'hFF0100,
        24'h01FF00, 24'h00FF01, 24'h0100FF, 24'h0001FF,
        24'h010000, 24'h000100, 24'h000001, 24'hFFFEFE,
        24'hFEFFFF, 24'h7F80FF, 24'hAA5500, 24'h123456
    };

    typedef enum logic [1:0] {
        PIX_UNIFORM,
        PIX_NEAR_GREY,
        PIX_TIED,
        PIX_DARK
    } t_pixel_kind;

    logic                  i_clk    = 1'b0;
    logic                  i_rst_n  = 1'b0;
    logic                  start    = 1'b0;
    logic [COLOR_BITS-1:0] red_px   = '0;
    logic [COLOR_BITS-1:0] green_px = '0;
    logic [COLOR_BITS-1:0] blue_px  = '0;

    logic                          busy;
    logic                          o_strobe;
    logic [rgb2hsv_pkg::HUE_W-1:0] o_hue_out;
    logic [COLOR_BITS-1:0]         o_sat_out;
    logic [COLOR_BITS-1:0]         o_val_out;
    logic                          o_hue_undefined;

    int fail_count;
    int pending_count;
    int checked_count;
    int undef_count;
    int cycle_count = 0;
    bit calm_stretch = 1'b0;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    rgb_to_hsv_convert #(
        .COLOR_BITS(COLOR_BITS)
    ) i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_red_in       (red_px),
        .i_green_in     (green_px),
        .i_blue_in      (blue_px),
        .o_strobe       (o_strobe),
        .o_hue_out      (o_hue_out),
        .o_sat_out      (o_sat_out),
        .o_val_out      (o_val_out),
        .o_hue_undefined(o_hue_undefined)
    );

    rgb_to_hsv_convert_chk #(
        .COLOR_BITS(COLOR_BITS)
    ) u_hsv_check (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (start),
        .i_busy         (busy),
        .i_red          (red_px),
        .i_green        (green_px),
        .i_blue         (blue_px),
        .i_strobe       (o_strobe),
        .i_hue          (o_hue_out),
        .i_sat          (o_sat_out),
        .i_val          (o_val_out),
        .i_hue_undefined(o_hue_undefined),
        .o_fail_count   (fail_count),
        .o_pending      (pending_count),
        .o_checked      (checked_count),
        .o_undef_seen   (undef_count)
    );

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    function automatic int idle_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (calm_stretch || roll < 60) return 0;
        if (roll < 90) return $urandom_range(1, 3);
        if (roll < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [COLOR_BITS-1:0] clamp_channel(input int value);
        if (value < 0) return '0;
        if (value > CHANNEL_MAX) return CHANNEL_MAX[COLOR_BITS-1:0];
        return value[COLOR_BITS-1:0];
    endfunction

    task automatic send_pixel(input logic [COLOR_BITS-1:0] r,
                              input logic [COLOR_BITS-1:0] g,
                              input logic [COLOR_BITS-1:0] b);
        int gap;
        gap = idle_gap();
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start    <= 1'b1;
        red_px   <= r;
        green_px <= g;
        blue_px  <= b;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
    endtask

    task automatic send_random_pixel();
        t_pixel_kind           kind;
        int                    base;
        logic [COLOR_BITS-1:0] r;
        logic [COLOR_BITS-1:0] g;
        logic [COLOR_BITS-1:0] b;
        logic [COLOR_BITS-1:0] shared;
        kind = t_pixel_kind'($urandom_range(0, 3));
        r = COLOR_BITS'($urandom_range(0, CHANNEL_MAX));
        g = COLOR_BITS'($urandom_range(0, CHANNEL_MAX));
        b = COLOR_BITS'($urandom_range(0, CHANNEL_MAX));
        case (kind)
            PIX_NEAR_GREY: begin
                base = $urandom_range(0, CHANNEL_MAX);
                r = clamp_channel(base + $urandom_range(0, 4) - 2);
                g = clamp_channel(base + $urandom_range(0, 4) - 2);
                b = clamp_channel(base + $urandom_range(0, 4) - 2);
            end
            PIX_TIED: begin
                shared = COLOR_BITS'($urandom_range(0, CHANNEL_MAX));
                case ($urandom_range(0, 2))
                    0: begin
                        r = shared;
                        g = shared;
                    end
                    1: begin
                        g = shared;
                        b = shared;
                    end
                    default: begin
                        r = shared;
                        b = shared;
                    end
                endcase
            end
            PIX_DARK: begin
                r = COLOR_BITS'($urandom_range(0, 7));
                g = COLOR_BITS'($urandom_range(0, 7));
                b = COLOR_BITS'($urandom_range(0, 7));
            end
            default: begin
            end
        endcase
        send_pixel(r, g, b);
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int k = 0; k < EDGE_COUNT; k++) begin
            send_pixel(EDGE_PIXELS[k][23:16], EDGE_PIXELS[k][15:8], EDGE_PIXELS[k][7:0]);
        end

        for (int n = 0; n < RANDOM_PIXELS; n++) begin
            if (n % 100 == 0) calm_stretch = ($urandom_range(0, 3) == 0);
            send_random_pixel();
        end
        start <= 1'b0;

        @(negedge i_clk);
        while (pending_count != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Checked %0d result words from %0d edge pixels and %0d random pixels;",
                 checked_count, EDGE_COUNT, RANDOM_PIXELS);
        $display("%0d of them had an undefined hue, with random idle gaps on the input.",
                 undef_count);
        if (fail_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

[files.f]
design/rgb2hsv_pkg.sv
design/rgb2hsv_front.sv
design/rgb2hsv_div.sv
design/rgb2hsv_back.sv
design/rgb_to_hsv_convert.sv
dv/rgb_to_hsv_convert_chk.sv
dv/rgb_to_hsv_convert_tb.sv
